// ----- design/energy_voice_activity_detector_macros.svh -----
// ----------------------------------------------------------------------------
// energy voice activity detector assertion macros
// Short forms for the same-cycle and next-cycle implication checks.
// ----------------------------------------------------------------------------
`ifndef ENERGY_VOICE_ACTIVITY_DETECTOR_MACROS_SVH
`define ENERGY_VOICE_ACTIVITY_DETECTOR_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define EVAD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define EVAD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/evad_pkg.sv -----
// ----------------------------------------------------------------------------
// evad_pkg
// Shared types, widths and register codes of the voice activity detector.
// ----------------------------------------------------------------------------
package evad_pkg;

    localparam int MAX_FRAME_SAMPLES_DEF = 1024;

    localparam int SAMPLE_W = 16;
    localparam int SQ_W     = 32;
    localparam int SUM_W    = 41;
    localparam int THR_W    = 31;
    localparam int CNT16_W  = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 31;
    localparam int IN_TDATA_W = 16;
    localparam int OUT_TDATA_W = 8;

    localparam logic [THR_W-1:0]   THRESHOLD_RST   = 31'd250000;
    localparam logic [CNT16_W-1:0] MIN_SPEECH_RST  = 16'd3;
    localparam logic [CNT16_W-1:0] MIN_SILENCE_RST = 16'd10;
    localparam logic [CNT16_W-1:0] CNT16_MAX       = 16'hFFFF;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_SPEECH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_SILENCE = 2'd2;

    typedef enum logic [2:0] {
        PH_SILENCE = 3'b001,
        PH_START   = 3'b010,
        PH_ONGOING = 3'b100
    } t_phase;

    typedef enum logic [1:0] {
        V_SILENCE = 2'd0,
        V_START   = 2'd1,
        V_ONGOING = 2'd2,
        V_END     = 2'd3
    } t_verdict;

    // frame-end status from the energy datapath
    typedef struct packed {
        logic done;
        logic speech;
    } t_frame;

endpackage

// ----- design/evad_energy.sv -----
// ----------------------------------------------------------------------------
// evad_energy
// Squares samples, accumulates frame energy and compares it against
// threshold times sample count at each frame end.
// ----------------------------------------------------------------------------
module evad_energy #(
    parameter int MAX_FRAME_SAMPLES = evad_pkg::MAX_FRAME_SAMPLES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  logic                              i_valid,
    input  logic [evad_pkg::SAMPLE_W-1:0]     i_sample,
    input  logic                              i_last,
    input  logic [evad_pkg::THR_W-1:0]        i_threshold,
    output evad_pkg::t_frame                  o_frame
);

    localparam int CNT_W  = $clog2(MAX_FRAME_SAMPLES + 1);
    localparam int PROD_W = evad_pkg::THR_W + CNT_W;
    localparam int CMP_W  = (PROD_W > evad_pkg::SUM_W) ? PROD_W : evad_pkg::SUM_W;
    localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(MAX_FRAME_SAMPLES);

    // stage 1: input register
    logic                          r_s1_valid;
    logic [evad_pkg::SAMPLE_W-1:0] r_s1_sample;
    logic                          r_s1_last;
    logic [CNT_W-1:0]              r_cnt;

    // stage 2: square
    logic                          r_s2_valid;
    logic [evad_pkg::SQ_W-1:0]     r_s2_sq;
    logic                          r_s2_end;
    logic [CNT_W-1:0]              r_s2_cnt;

    // stage 3: frame totals
    logic                          r_s3_valid;
    logic [evad_pkg::SUM_W-1:0]    r_s3_sum;
    logic [PROD_W-1:0]             r_s3_prod;
    logic [evad_pkg::SUM_W-1:0]    r_acc;

    logic [evad_pkg::SAMPLE_W-1:0] w_mag;
    logic [evad_pkg::SQ_W-1:0]     w_sq;
    logic [CNT_W-1:0]              w_cnt_inc;
    logic                          w_end;
    logic [evad_pkg::SUM_W:0]      w_sum_full;
    logic [evad_pkg::SUM_W-1:0]    w_sum_sat;

    // magnitude of -32768 is 0x8000, which still fits unsigned
    assign w_mag     = r_s1_sample[evad_pkg::SAMPLE_W-1] ?
                       (evad_pkg::SAMPLE_W'(0) - r_s1_sample) : r_s1_sample;
    assign w_sq      = evad_pkg::SQ_W'(w_mag) * evad_pkg::SQ_W'(w_mag);
    assign w_cnt_inc = r_cnt + CNT_W'(1);
    // an overlong frame closes on its last allowed sample
    assign w_end     = r_s1_last || (w_cnt_inc == CNT_LIMIT);

    assign w_sum_full = {1'b0, r_acc} + (evad_pkg::SUM_W + 1)'(r_s2_sq);
    assign w_sum_sat  = w_sum_full[evad_pkg::SUM_W] ? {evad_pkg::SUM_W{1'b1}}
                                                    : w_sum_full[evad_pkg::SUM_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_cnt      <= '0;
            r_acc      <= '0;
        end else if (i_en) begin
            r_s1_valid <= i_valid;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid && r_s2_end;
            if (r_s1_valid) begin
                r_cnt <= w_end ? '0 : w_cnt_inc;
            end
            if (r_s2_valid) begin
                r_acc <= r_s2_end ? '0 : w_sum_sat;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1_sample <= i_sample;
            r_s1_last   <= i_last;
            r_s2_sq     <= w_sq;
            r_s2_end    <= w_end;
            r_s2_cnt    <= w_cnt_inc;
            r_s3_sum    <= w_sum_sat;
            r_s3_prod   <= PROD_W'(i_threshold) * PROD_W'(r_s2_cnt);
        end
    end

    assign o_frame.done   = r_s3_valid;
    assign o_frame.speech = CMP_W'(r_s3_sum) > CMP_W'(r_s3_prod);

endmodule

// ----- design/energy_voice_activity_detector.sv -----
// ----------------------------------------------------------------------------
// energy_voice_activity_detector
// Frame energy voice activity detector with speech start/ongoing/end verdicts.
// ----------------------------------------------------------------------------
// Takes one signed 16-bit sample per clock on the slave stream while tready
// is high, tlast marking the last sample of a frame (a frame is also closed
// after MAX_FRAME_SAMPLES samples). At each frame end one result is sent on
// the master stream: the verdict and whether the frame's mean-square energy
// exceeded the threshold. Throughput is one sample per cycle, stalls apart,
// through a four-register pipeline (input, square, accumulate with threshold
// product, compare and verdict). The input stalls only while a result sits
// unread in the output register and the next frame's result has reached the
// verdict stage. The user is to write configuration through the write port
// only while the stream is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
`include "energy_voice_activity_detector_macros.svh"

module energy_voice_activity_detector #(
    parameter int MAX_FRAME_SAMPLES = evad_pkg::MAX_FRAME_SAMPLES_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_s_tvalid,
    output logic                                 o_s_tready,
    input  logic [evad_pkg::IN_TDATA_W-1:0]      i_s_tdata,   // [15:0] sample
    input  logic                                 i_s_tlast,   // frame_last
    output logic                                 o_m_tvalid,
    input  logic                                 i_m_tready,
    // [1:0] frame_verdict, [2] frame_is_speech, [7:3] zero
    output logic [evad_pkg::OUT_TDATA_W-1:0]     o_m_tdata,
    input  logic                                 i_cfg_we,
    input  logic [evad_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [evad_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    logic [evad_pkg::THR_W-1:0]   r_threshold;
    logic [evad_pkg::CNT16_W-1:0] r_min_speech;
    logic [evad_pkg::CNT16_W-1:0] r_min_silence;

    evad_pkg::t_phase             r_phase;
    evad_pkg::t_phase             n_phase;
    logic [evad_pkg::CNT16_W-1:0] r_speech_cnt;
    logic [evad_pkg::CNT16_W-1:0] n_speech_cnt;
    logic [evad_pkg::CNT16_W-1:0] r_silence_cnt;
    logic [evad_pkg::CNT16_W-1:0] n_silence_cnt;

    logic                         r_out_valid;
    evad_pkg::t_verdict           r_out_verdict;
    evad_pkg::t_verdict           n_verdict;
    logic                         r_out_speech;

    evad_pkg::t_frame             w_frame;
    logic                         w_en;
    logic [evad_pkg::CNT16_W-1:0] w_speech_inc;
    logic [evad_pkg::CNT16_W-1:0] w_silence_inc;

    // hold the pipeline only when a new frame result would overwrite an unread one
    assign w_en       = !(w_frame.done && r_out_valid && !i_m_tready);
    assign o_s_tready = w_en;

    evad_energy #(
        .MAX_FRAME_SAMPLES (MAX_FRAME_SAMPLES)
    ) u_energy (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (w_en),
        .i_valid     (i_s_tvalid),
        .i_sample    (i_s_tdata[evad_pkg::SAMPLE_W-1:0]),
        .i_last      (i_s_tlast),
        .i_threshold (r_threshold),
        .o_frame     (w_frame)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold   <= evad_pkg::THRESHOLD_RST;
            r_min_speech  <= evad_pkg::MIN_SPEECH_RST;
            r_min_silence <= evad_pkg::MIN_SILENCE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                evad_pkg::REG_THRESHOLD: begin
                    r_threshold <= i_cfg_data;
                end
                evad_pkg::REG_MIN_SPEECH: begin
                    r_min_speech <= i_cfg_data[evad_pkg::CNT16_W-1:0];
                end
                evad_pkg::REG_MIN_SILENCE: begin
                    r_min_silence <= i_cfg_data[evad_pkg::CNT16_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // saturating frame counters
    assign w_speech_inc  = (r_speech_cnt == evad_pkg::CNT16_MAX) ?
                           r_speech_cnt : r_speech_cnt + evad_pkg::CNT16_W'(1);
    assign w_silence_inc = (r_silence_cnt == evad_pkg::CNT16_MAX) ?
                           r_silence_cnt : r_silence_cnt + evad_pkg::CNT16_W'(1);

    always_comb begin
        n_phase       = r_phase;
        n_speech_cnt  = r_speech_cnt;
        n_silence_cnt = r_silence_cnt;
        n_verdict     = evad_pkg::V_SILENCE;
        case (r_phase)
            evad_pkg::PH_START, evad_pkg::PH_ONGOING: begin
                if (w_frame.speech) begin
                    n_speech_cnt  = w_speech_inc;
                    n_silence_cnt = '0;
                    n_phase       = evad_pkg::PH_ONGOING;
                    n_verdict     = evad_pkg::V_ONGOING;
                end else begin
                    n_silence_cnt = w_silence_inc;
                    if ((w_silence_inc >= r_min_silence) &&
                        (r_speech_cnt >= r_min_speech)) begin
                        n_phase   = evad_pkg::PH_SILENCE;
                        n_verdict = evad_pkg::V_END;
                    end else begin
                        n_verdict = evad_pkg::V_ONGOING;
                    end
                end
            end
            default: begin
                if (w_frame.speech) begin
                    n_speech_cnt  = evad_pkg::CNT16_W'(1);
                    n_silence_cnt = '0;
                    n_phase       = evad_pkg::PH_START;
                    n_verdict     = evad_pkg::V_START;
                end else begin
                    n_phase   = evad_pkg::PH_SILENCE;
                    n_verdict = evad_pkg::V_SILENCE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= evad_pkg::PH_SILENCE;
            r_speech_cnt  <= '0;
            r_silence_cnt <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (w_frame.done && w_en) begin
                r_phase       <= n_phase;
                r_speech_cnt  <= n_speech_cnt;
                r_silence_cnt <= n_silence_cnt;
                r_out_valid   <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid   <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_frame.done && w_en) begin
            r_out_verdict <= n_verdict;
            r_out_speech  <= w_frame.speech;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {5'b0, r_out_speech, r_out_verdict};

    `EVAD_ASSERT_NOW(a_start_is_speech, i_clk, i_rst_n,
        o_m_tvalid && (r_out_verdict == evad_pkg::V_START), r_out_speech,
        "start verdict on a silent frame")
    `EVAD_ASSERT_NOW(a_end_is_silent, i_clk, i_rst_n,
        o_m_tvalid && (r_out_verdict == evad_pkg::V_END), !r_out_speech,
        "end verdict on a speech frame")
    `EVAD_ASSERT_NOW(a_active_has_speech, i_clk, i_rst_n,
        r_phase != evad_pkg::PH_SILENCE, r_speech_cnt != '0,
        "active phase with zero speech count")
    `EVAD_ASSERT_NEXT(a_silence_to_start, i_clk, i_rst_n,
        w_en && w_frame.done && w_frame.speech && (r_phase == evad_pkg::PH_SILENCE),
        (r_phase == evad_pkg::PH_START) && (r_speech_cnt == evad_pkg::CNT16_W'(1)),
        "speech frame in silence did not start")

endmodule
